@@ src/ssi_pkg.sv @@
// Shared types and constants for the segment/sphere intersection block.
// No dependencies; every other file of the block but ssi_smul imports this package.
package ssi_pkg;

    // Field and datapath widths
    localparam int COORD_W = 32;   // Q16.16 coordinate
    localparam int DIFF_W  = 33;   // exact difference of two coordinates
    localparam int RED_W   = 29;   // difference floored to Q.12
    localparam int ACC_W   = 60;   // a, h, c accumulators
    localparam int MAG_W   = 58;   // magnitudes of a, h, c
    localparam int PROD_W  = 116;  // h*h and a*c
    localparam int Q_W     = 118;  // discriminant, padded to an even width
    localparam int ROOT_W  = 59;   // floor(sqrt(q))
    localparam int REM_W   = 62;   // square root remainder
    localparam int NUM_W   = 58;   // root numerator, 0..a
    localparam int QUO_W   = 33;   // offset along one axis
    localparam int RAD_W   = 31;   // sphere radius register
    localparam int HITS_W  = 18;   // hit count port

    // Front-to-back queue depth (power of two)
    localparam int QDEPTH  = 2;

    // Product schedule of the a/h/c pass
    localparam logic [3:0] K_H   = 4'd3;
    localparam logic [3:0] K_C   = 4'd6;
    localparam logic [3:0] K_R   = 4'd9;
    localparam logic [3:0] K_END = 4'd10;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    // One classified edge as it waits between front and back
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p;    // first endpoint
        logic [2:0][DIFF_W-1:0]  d;    // end - start
        logic [2:0][RED_W-1:0]   dr;   // floor(d / 16)
        logic [2:0][RED_W-1:0]   fr;   // floor((start - center) / 16)
        logic                    first;
        logic                    zero; // floored length vanishes
    } t_edge;

endpackage

@@ src/ssi_front.sv @@
// Front end: forms edge direction and center offset and flags edges whose floored length vanishes.
// Depends on ssi_pkg.
module ssi_front (
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic               i_first_edge,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    output ssi_pkg::t_edge     o_edge
);
    import ssi_pkg::*;

    logic signed [2:0][COORD_W-1:0] w_s;
    logic signed [2:0][COORD_W-1:0] w_e;
    logic signed [2:0][COORD_W-1:0] w_c;
    logic [2:0][DIFF_W-1:0]         w_d;
    logic [2:0][DIFF_W-1:0]         w_f;

    assign w_s = {i_start_z, i_start_y, i_start_x};
    assign w_e = {i_end_z, i_end_y, i_end_x};
    assign w_c = {i_center_z, i_center_y, i_center_x};

    // Take exact differences, then floor to Q.12 by an arithmetic shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = DIFF_W'($signed(w_e[i])) - DIFF_W'($signed(w_s[i]));
            w_f[i] = DIFF_W'($signed(w_s[i])) - DIFF_W'($signed(w_c[i]));
            o_edge.d[i]  = w_d[i];
            o_edge.p[i]  = w_s[i];
            o_edge.dr[i] = w_d[i][DIFF_W-1:4];
            o_edge.fr[i] = w_f[i][DIFF_W-1:4];
        end
        o_edge.first = i_first_edge;
        o_edge.zero  = (w_d[0][DIFF_W-1:4] == '0) && (w_d[1][DIFF_W-1:4] == '0)
                    && (w_d[2][DIFF_W-1:4] == '0);
    end

endmodule

@@ src/ssi_queue.sv @@
// Short register queue between front and back end.
// Depends on ssi_pkg (t_edge, QDEPTH).
module ssi_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssi_pkg::t_edge i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ssi_pkg::t_edge o_data
);
    import ssi_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_edge              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Store the request
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/ssi_smul.sv @@
// Bit-serial unsigned multiplier: one bit of the multiplier per cycle.
// Depends on nothing but the parameters AW and BW.
module ssi_smul #(
    parameter int AW = 58,
    parameter int BW = 58
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_prod,
    output logic             o_done
);
    localparam int CNT_W = $clog2(BW + 1);

    logic [AW-1:0]    r_a;
    logic [AW-1:0]    r_hi;
    logic [BW-1:0]    r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [AW:0]      w_sum;

    assign w_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    assign o_prod = {r_hi, r_lo};
    assign o_done = r_done;

    // Add the multiplicand when the low bit is set, then shift right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[AW:1];
            r_lo <= {w_sum[0], r_lo[BW-1:1]};
        end
    end

    // Count steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ src/ssi_lane.sv @@
// One axis of one root: offset = floor(|D| * n / a), serial multiply then divide.
// Depends on ssi_pkg and ssi_smul.
module ssi_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ssi_pkg::QUO_W-1:0]   i_mag,
    input  logic [ssi_pkg::NUM_W-1:0]   i_num,
    input  logic [ssi_pkg::NUM_W-1:0]   i_den,
    output logic [ssi_pkg::QUO_W-1:0]   o_off,
    output logic                        o_done
);
    import ssi_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } t_lstate;

    localparam int CNT_W = $clog2(QUO_W + 1);

    t_lstate                r_state;
    logic [NUM_W-1:0]       r_den;
    logic [NUM_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_done;
    logic [NUM_W+QUO_W-1:0] w_prod;
    logic                   w_mdone;
    logic [NUM_W:0]         w_rem2;
    logic                   w_ge;

    ssi_smul #(
        .AW(NUM_W),
        .BW(QUO_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_a     (i_num),
        .i_b     (i_mag),
        .o_prod  (w_prod),
        .o_done  (w_mdone)
    );

    assign w_rem2 = {r_rem, r_quo[QUO_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign o_off  = r_quo;
    assign o_done = r_done;

    // Restoring division; quotient bits shift in where the dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
        end
        if (r_state == L_MUL && w_mdone) begin
            r_rem <= w_prod[NUM_W+QUO_W-1:QUO_W];
            r_quo <= w_prod[QUO_W-1:0];
        end else if (r_state == L_DIV) begin
            r_rem <= w_ge ? NUM_W'(w_rem2 - {1'b0, r_den}) : w_rem2[NUM_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    // Sequence multiply and divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (w_mdone) begin
                        r_cnt   <= CNT_W'(QUO_W);
                        r_state <= L_DIV;
                    end
                end
                L_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

endmodule

@@ src/ssi_back.sv @@
// Back end: quadratic coefficients, discriminant, square root, roots and points.
// Depends on ssi_pkg, ssi_smul and ssi_lane; holds the result register.
module ssi_back #(
    parameter int MAX_EDGES = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssi_pkg::t_edge                i_edge,
    input  logic                          i_edge_valid,
    output logic                          o_edge_pop,
    input  logic [ssi_pkg::RAD_W-1:0]     i_radius,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_plus_root_valid,
    output logic signed [31:0]            o_plus_hit_x,
    output logic signed [31:0]            o_plus_hit_y,
    output logic signed [31:0]            o_plus_hit_z,
    output logic                          o_minus_root_valid,
    output logic signed [31:0]            o_minus_hit_x,
    output logic signed [31:0]            o_minus_hit_y,
    output logic signed [31:0]            o_minus_hit_z,
    output logic [ssi_pkg::HITS_W-1:0]    o_total_hits
);
    import ssi_pkg::*;

    localparam int HIT_LIMIT = 2 * MAX_EDGES;
    localparam int CW        = $clog2(HIT_LIMIT + 1);
    localparam int SCNT_W    = $clog2(ROOT_W + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ABC   = 8'b0000_0010,
        S_QGO   = 8'b0000_0100,
        S_QMUL  = 8'b0000_1000,
        S_SQRT  = 8'b0001_0000,
        S_ROOT  = 8'b0010_0000,
        S_SGO   = 8'b0100_0000,
        S_SCALE = 8'b1000_0000
    } t_bstate;

    t_bstate                 r_state;
    logic                    r_fin;      // result ready to hand over
    t_edge                   r_e;
    logic [3:0]              r_k;
    logic signed [2*RED_W-1:0] r_prod;
    logic [3:0]              r_ptag;
    logic                    r_pvalid;
    logic signed [ACC_W-1:0] r_a;
    logic signed [ACC_W-1:0] r_h;
    logic signed [ACC_W-1:0] r_c;
    logic [Q_W-1:0]          r_q;
    logic                    r_qnz;
    logic [REM_W-1:0]        r_rem;
    logic [ROOT_W-1:0]       r_root;
    logic [SCNT_W-1:0]       r_cnt;
    logic                    r_pv;
    logic                    r_mv;
    logic [NUM_W-1:0]        r_np;
    logic [NUM_W-1:0]        r_nm;
    logic [CW-1:0]           r_hits;
    logic                    r_ov;
    logic                    r_opv;
    logic                    r_omv;
    logic [2:0][31:0]        r_ohp;
    logic [2:0][31:0]        r_ohm;

    // Coefficient pass
    logic [1:0]                w_ax;
    logic signed [RED_W-1:0]   w_mx;
    logic signed [RED_W-1:0]   w_my;
    logic signed [RED_W-1:0]   w_rr;
    logic signed [2*RED_W-1:0] w_mul;
    logic signed [ACC_W-1:0]   w_pe;

    // Discriminant
    logic [ACC_W-1:0]  w_habs;
    logic [ACC_W-1:0]  w_cabs;
    logic [PROD_W-1:0] w_hh;
    logic [PROD_W-1:0] w_ac;
    logic              w_hh_done;
    logic              w_ac_done;
    logic [PROD_W:0]   w_q;

    // Square root step
    logic [REM_W-1:0] w_rsh;
    logic [REM_W-1:0] w_trial;
    logic             w_rge;

    // Roots
    logic signed [REM_W-1:0] w_hx;
    logic signed [REM_W-1:0] w_np;
    logic signed [REM_W-1:0] w_nm;
    logic [REM_W-1:0]        w_ax62;
    logic                    w_pv;
    logic                    w_mv;

    // Lanes and result
    logic                    w_lgo;
    logic [5:0]              w_ldone;
    logic [2:0][QUO_W-1:0]   w_dmag;
    logic [2:0][QUO_W-1:0]   w_offp;
    logic [2:0][QUO_W-1:0]   w_offm;
    logic [2:0][31:0]        w_hp;
    logic [2:0][31:0]        w_hm;
    logic                    w_take;
    logic [CW-1:0]           w_base;
    logic [CW:0]             w_sum;
    logic [CW-1:0]           w_hits;
    logic [CW+HITS_W-1:0]    w_hwide;

    // Pick the operands of product k: a terms, h terms, c terms, then rr*rr
    always_comb begin
        if (r_k < K_H) begin
            w_ax = r_k[1:0];
        end else if (r_k < K_C) begin
            w_ax = 2'(r_k - K_H);
        end else if (r_k < K_R) begin
            w_ax = 2'(r_k - K_C);
        end else begin
            w_ax = '0;
        end
        w_rr = $signed({2'b00, i_radius[RAD_W-1:4]});
        if (r_k < K_H) begin
            w_mx = $signed(r_e.dr[w_ax]);
            w_my = $signed(r_e.dr[w_ax]);
        end else if (r_k < K_C) begin
            w_mx = $signed(r_e.dr[w_ax]);
            w_my = $signed(r_e.fr[w_ax]);
        end else if (r_k < K_R) begin
            w_mx = $signed(r_e.fr[w_ax]);
            w_my = $signed(r_e.fr[w_ax]);
        end else begin
            w_mx = w_rr;
            w_my = w_rr;
        end
    end

    assign w_mul = w_mx * w_my;
    assign w_pe  = ACC_W'(r_prod);

    // Magnitudes for the wide products
    assign w_habs = r_h[ACC_W-1] ? ACC_W'(-r_h) : ACC_W'(r_h);
    assign w_cabs = r_c[ACC_W-1] ? ACC_W'(-r_c) : ACC_W'(r_c);

    ssi_smul #(
        .AW(MAG_W),
        .BW(MAG_W)
    ) u_hh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_QGO),
        .i_a     (w_habs[MAG_W-1:0]),
        .i_b     (w_habs[MAG_W-1:0]),
        .o_prod  (w_hh),
        .o_done  (w_hh_done)
    );

    ssi_smul #(
        .AW(MAG_W),
        .BW(MAG_W)
    ) u_ac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_QGO),
        .i_a     (r_a[MAG_W-1:0]),
        .i_b     (w_cabs[MAG_W-1:0]),
        .o_prod  (w_ac),
        .o_done  (w_ac_done)
    );

    // q = h*h - a*c, taking the sign of c into account
    assign w_q = r_c[ACC_W-1] ? ({1'b0, w_hh} + {1'b0, w_ac}) : ({1'b0, w_hh} - {1'b0, w_ac});

    // Digit-by-digit square root, two bits of q per step
    assign w_rsh   = {r_rem[REM_W-3:0], r_q[Q_W-1:Q_W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_rge   = (w_rsh >= w_trial);

    // Root numerators n = -h +/- s and their range checks against a
    assign w_hx   = REM_W'(r_h);
    assign w_np   = -w_hx + $signed(REM_W'(r_root));
    assign w_nm   = -w_hx - $signed(REM_W'(r_root));
    assign w_ax62 = REM_W'(r_a[MAG_W-1:0]);
    assign w_pv   = !w_np[REM_W-1] && (w_np <= w_ax62);
    assign w_mv   = r_qnz && !w_nm[REM_W-1] && (w_nm <= w_ax62);

    // Scale lanes, one per axis and root
    assign w_lgo = (r_state == S_SGO);

    for (genvar g = 0; g < 3; g++) begin : g_axis
        assign w_dmag[g] = r_e.d[g][DIFF_W-1] ? QUO_W'(-$signed(r_e.d[g]))
                                              : QUO_W'(r_e.d[g]);

        ssi_lane u_plus (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_lgo),
            .i_mag   (w_dmag[g]),
            .i_num   (r_np),
            .i_den   (r_a[MAG_W-1:0]),
            .o_off   (w_offp[g]),
            .o_done  (w_ldone[g])
        );

        ssi_lane u_minus (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_lgo),
            .i_mag   (w_dmag[g]),
            .i_num   (r_nm),
            .i_den   (r_a[MAG_W-1:0]),
            .o_off   (w_offm[g]),
            .o_done  (w_ldone[g+3])
        );

        // Step from the first endpoint toward the second
        assign w_hp[g] = !r_pv ? '0 : (r_e.d[g][DIFF_W-1] ? r_e.p[g] - w_offp[g][31:0]
                                                          : r_e.p[g] + w_offp[g][31:0]);
        assign w_hm[g] = !r_mv ? '0 : (r_e.d[g][DIFF_W-1] ? r_e.p[g] - w_offm[g][31:0]
                                                          : r_e.p[g] + w_offm[g][31:0]);
    end

    // Hand over when the result register is free or being drained
    assign w_take = r_fin && (!r_ov || i_pop);

    // Running hit count, cleared by the first-edge flag, saturating
    assign w_base = r_e.first ? '0 : r_hits;
    assign w_sum  = (CW+1)'(w_base) + (CW+1)'(r_pv) + (CW+1)'(r_mv);
    assign w_hits = (w_sum > (CW+1)'(HIT_LIMIT)) ? CW'(HIT_LIMIT) : w_sum[CW-1:0];

    assign o_edge_pop = (r_state == S_IDLE) && !r_fin && i_edge_valid;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_edge_pop) begin
                    r_e    <= i_edge;
                    r_k    <= '0;
                    r_a    <= '0;
                    r_h    <= '0;
                    r_c    <= '0;
                    r_pv   <= 1'b0;
                    r_mv   <= 1'b0;
                end
            end
            S_ABC: begin
                if (r_k != K_END) begin
                    r_prod <= w_mul;
                    r_ptag <= r_k;
                    r_k    <= r_k + 1'b1;
                end
                if (r_pvalid) begin
                    if (r_ptag < K_H) begin
                        r_a <= r_a + w_pe;
                    end else if (r_ptag < K_C) begin
                        r_h <= r_h + w_pe;
                    end else if (r_ptag < K_R) begin
                        r_c <= r_c + w_pe;
                    end else begin
                        r_c <= r_c - w_pe;
                    end
                end
            end
            S_QMUL: begin
                if (w_hh_done) begin
                    r_q    <= {1'b0, w_q};
                    r_qnz  <= (w_q != '0);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= SCNT_W'(ROOT_W);
                end
            end
            S_SQRT: begin
                r_rem  <= w_rge ? w_rsh - w_trial : w_rsh;
                r_root <= {r_root[ROOT_W-2:0], w_rge};
                r_q    <= {r_q[Q_W-3:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
            end
            S_ROOT: begin
                r_pv <= w_pv;
                r_mv <= w_mv;
                r_np <= w_np[NUM_W-1:0];
                r_nm <= w_nm[NUM_W-1:0];
            end
            default: begin
            end
        endcase
        if (w_take) begin
            r_opv <= r_pv;
            r_omv <= r_mv;
            r_ohp <= w_hp;
            r_ohm <= w_hm;
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin    <= 1'b0;
            r_pvalid <= 1'b0;
            r_ov     <= 1'b0;
            r_hits   <= '0;
        end else begin
            if (w_take) begin
                r_fin  <= 1'b0;
                r_ov   <= 1'b1;
                r_hits <= w_hits;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_edge_pop) begin
                        r_pvalid <= 1'b0;
                        r_state  <= S_ABC;
                    end
                end
                S_ABC: begin
                    r_pvalid <= (r_k != K_END);
                    if (r_k == K_END) begin
                        if (r_e.zero) begin
                            r_fin   <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_QGO;
                        end
                    end
                end
                S_QGO: begin
                    r_state <= S_QMUL;
                end
                S_QMUL: begin
                    if (w_hh_done && w_ac_done) begin
                        // negative discriminant: no hit
                        if (!r_c[ACC_W-1] && (w_hh < w_ac)) begin
                            r_fin   <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_cnt == SCNT_W'(1)) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_pv || w_mv) begin
                        r_state <= S_SGO;
                    end else begin
                        r_fin   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SGO: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (&w_ldone) begin
                        r_fin   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_hwide            = {{HITS_W{1'b0}}, r_hits};
    assign o_empty            = !r_ov;
    assign o_plus_root_valid  = r_opv;
    assign o_plus_hit_x       = r_ohp[0];
    assign o_plus_hit_y       = r_ohp[1];
    assign o_plus_hit_z       = r_ohp[2];
    assign o_minus_root_valid = r_omv;
    assign o_minus_hit_x      = r_ohm[0];
    assign o_minus_hit_y      = r_ohm[1];
    assign o_minus_hit_z      = r_ohm[2];
    assign o_total_hits       = w_hwide[HITS_W-1:0];

endmodule

@@ src/segment_sphere_intersection_top.sv @@
// Each pushed edge (two Q16.16 endpoints) is intersected with the configured
// sphere and yields one result: up to two points on the edge and a running hit
// count that first_edge clears and that saturates at 2*MAX_EDGES. The back end
// takes an edge through the coefficient products, the bit-serial h*h and a*c
// multipliers, the square root at two discriminant bits a step, and the serial
// multiply and divide of the per-axis lanes, stopping early where no hit can
// follow; edges are worked one at a time.
// A two-entry queue keeps accepting edges while the back end works, and a result
// register holds the finished result until it is popped. Write the center and
// radius registers only while the block is idle; the write port is always ready.
// Depends on ssi_pkg, ssi_front, ssi_queue and ssi_back.
module segment_sphere_intersection_top #(
    parameter int MAX_EDGES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic               i_first_edge,
    output logic               empty,
    input  logic               pop,
    output logic               o_plus_root_valid,
    output logic signed [31:0] o_plus_hit_x,
    output logic signed [31:0] o_plus_hit_y,
    output logic signed [31:0] o_plus_hit_z,
    output logic               o_minus_root_valid,
    output logic signed [31:0] o_minus_hit_x,
    output logic signed [31:0] o_minus_hit_y,
    output logic signed [31:0] o_minus_hit_z,
    output logic [17:0]        o_total_hits,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ssi_pkg::*;

    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic signed [31:0] r_center_z;
    logic [RAD_W-1:0]   r_radius;
    t_edge              w_fedge;
    t_edge              w_qedge;
    logic               w_qvalid;
    logic               w_qpop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssi_front u_front (
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_start_z    (i_start_z),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_end_z      (i_end_z),
        .i_first_edge (i_first_edge),
        .i_center_x   (r_center_x),
        .i_center_y   (r_center_y),
        .i_center_z   (r_center_z),
        .o_edge       (w_fedge)
    );

    ssi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_fedge),
        .o_full  (full),
        .i_pop   (w_qpop),
        .o_valid (w_qvalid),
        .o_data  (w_qedge)
    );

    ssi_back #(
        .MAX_EDGES(MAX_EDGES)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_edge             (w_qedge),
        .i_edge_valid       (w_qvalid),
        .o_edge_pop         (w_qpop),
        .i_radius           (r_radius),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_plus_root_valid  (o_plus_root_valid),
        .o_plus_hit_x       (o_plus_hit_x),
        .o_plus_hit_y       (o_plus_hit_y),
        .o_plus_hit_z       (o_plus_hit_z),
        .o_minus_root_valid (o_minus_root_valid),
        .o_minus_hit_x      (o_minus_hit_x),
        .o_minus_hit_y      (o_minus_hit_y),
        .o_minus_hit_z      (o_minus_hit_z),
        .o_total_hits       (o_total_hits)
    );

endmodule

@@ bench/tb_segment_sphere_intersection_top.sv @@
// Self-checking bench for segment_sphere_intersection_top: drives edges through the
// push/full queue port, predicts each result in fixed point and checks every popped one.
// Depends on ssi_pkg and the segment_sphere_intersection_top RTL.
module tb_segment_sphere_intersection_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ssi_pkg::*;

    localparam int HIT_LIMIT  = 2 * 65536;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 250;

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic               first;
    } t_edge_req;

    typedef struct {
        logic               pv;
        logic signed [31:0] px, py, pz;
        logic               mv;
        logic signed [31:0] mx, my, mz;
        logic [17:0]        hits;
    } t_hit_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [31:0] sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0;
    logic first_edge = 1'b0;
    logic cfg_valid = 1'b0;
    t_cfg_idx cfg_index = CFG_CENTER_X;
    logic [31:0] cfg_data = '0;
    logic cfg_ready;
    logic o_pv, o_mv;
    logic signed [31:0] o_px, o_py, o_pz, o_mx, o_my, o_mz;
    logic [17:0] o_hits;

    // predictor state
    longint ctr[3];
    logic [30:0] radius;
    int hit_count;

    t_edge_req pending_edges[$];
    t_hit_res  expected_hits[$];
    t_edge_req cur_edge;
    int push_gap, pop_stall, idle_cycles;
    int mismatches, edges_sent, results_checked, two_hit_edges, tangent_like;
    bit calm;

    segment_sphere_intersection_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_start_x(sx), .i_start_y(sy), .i_start_z(sz),
        .i_end_x(ex), .i_end_y(ey), .i_end_z(ez),
        .i_first_edge(first_edge),
        .empty(empty), .pop(pop),
        .o_plus_root_valid(o_pv),
        .o_plus_hit_x(o_px), .o_plus_hit_y(o_py), .o_plus_hit_z(o_pz),
        .o_minus_root_valid(o_mv),
        .o_minus_hit_x(o_mx), .o_minus_hit_y(o_my), .o_minus_hit_z(o_mz),
        .o_total_hits(o_hits),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] q);
        logic [127:0] root, t;
        root = '0;
        for (int b = 62; b >= 0; b--) begin
            t = root | (128'd1 << b);
            if (t * t <= q) root = t;
        end
        return root;
    endfunction

    // Point on the edge at numerator n over a, truncated toward the start point
    function automatic logic signed [31:0] along(longint p, longint d, longint n, longint a);
        logic [127:0] prod, off;
        longint m;
        m = (d < 0) ? -d : d;
        prod = 128'(m) * 128'(n);
        off = prod / 128'(a);
        if (d < 0) return 32'(p - longint'(off));
        return 32'(p + longint'(off));
    endfunction

    // Solve one edge against the sphere and advance the hit count
    function automatic t_hit_res solve_edge(t_edge_req e);
        t_hit_res r;
        longint p[3], d[3], dr[3], fr[3];
        longint a, h, c, rr, s, np, nm;
        logic signed [127:0] q, hw, aw, cw;
        r = '{default: '0};
        p[0] = e.sx; p[1] = e.sy; p[2] = e.sz;
        d[0] = longint'(e.ex) - p[0];
        d[1] = longint'(e.ey) - p[1];
        d[2] = longint'(e.ez) - p[2];
        a = 0; h = 0; c = 0;
        for (int i = 0; i < 3; i++) begin
            dr[i] = d[i] >>> 4;
            fr[i] = (p[i] - ctr[i]) >>> 4;
            a += dr[i] * dr[i];
            h += dr[i] * fr[i];
            c += fr[i] * fr[i];
        end
        rr = longint'(radius) / 16;
        c -= rr * rr;
        if (e.first) hit_count = 0;
        if (a != 0) begin
            hw = h; aw = a; cw = c;
            q = hw * hw - aw * cw;
            if (q >= 0) begin
                s = longint'(isqrt(q));
                np = -h + s;
                nm = -h - s;
                if (q == 0) tangent_like++;
                if (np >= 0 && np <= a) begin
                    r.pv = 1'b1;
                    r.px = along(p[0], d[0], np, a);
                    r.py = along(p[1], d[1], np, a);
                    r.pz = along(p[2], d[2], np, a);
                end
                if (q > 0 && nm >= 0 && nm <= a) begin
                    r.mv = 1'b1;
                    r.mx = along(p[0], d[0], nm, a);
                    r.my = along(p[1], d[1], nm, a);
                    r.mz = along(p[2], d[2], nm, a);
                end
            end
        end
        if (r.pv && r.mv) two_hit_edges++;
        hit_count = hit_count + r.pv + r.mv;
        if (hit_count > HIT_LIMIT) hit_count = HIT_LIMIT;
        r.hits = 18'(hit_count);
        return r;
    endfunction

    // Driver: hand over the current request, then load the next after a gap
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                expected_hits.insert(expected_hits.size(), solve_edge(cur_edge));
                edges_sent++;
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (pending_edges.size() > 0) begin
                cur_edge = pending_edges.pop_front();
                sx <= cur_edge.sx; sy <= cur_edge.sy; sz <= cur_edge.sz;
                ex <= cur_edge.ex; ey <= cur_edge.ey; ez <= cur_edge.ez;
                first_edge <= cur_edge.first;
                push <= 1'b1;
                push_gap = gap_len();
            end else begin
                push <= 1'b0;
            end
        end
    end

    task automatic report(string name, longint e, longint a);
        if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH result %0d %s: expected %0d got %0d",
                         results_checked, name, e, a);
        end
    endtask

    // Monitor: check each popped result against the oldest prediction
    always @(posedge i_clk) begin
        t_hit_res x;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("MISMATCH unexpected result");
                end else begin
                    x = expected_hits.pop_front();
                    report("plus_root_valid", x.pv, o_pv);
                    report("plus_hit_x", x.px, o_px);
                    report("plus_hit_y", x.py, o_py);
                    report("plus_hit_z", x.pz, o_pz);
                    report("minus_root_valid", x.mv, o_mv);
                    report("minus_hit_x", x.mx, o_mx);
                    report("minus_hit_y", x.my, o_my);
                    report("minus_hit_z", x.mz, o_mz);
                    report("total_hits", x.hits, o_hits);
                end
                results_checked++;
                pop_stall = gap_len();
            end
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted request of any kind
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER_X: ctr[0] = longint'(signed'(val));
            CFG_CENTER_Y: ctr[1] = longint'(signed'(val));
            CFG_CENTER_Z: ctr[2] = longint'(signed'(val));
            default:      radius = val[30:0];
        endcase
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] r);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, r);
    endtask

    // Hold the sender until every queued edge has been answered
    task automatic drain();
        while (pending_edges.size() > 0 || push || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_edge(longint a0, longint a1, longint a2,
                            longint b0, longint b1, longint b2, bit f);
        t_edge_req e;
        e.sx = 32'(a0); e.sy = 32'(a1); e.sz = 32'(a2);
        e.ex = 32'(b0); e.ey = 32'(b1); e.ez = 32'(b2);
        e.first = f;
        pending_edges.insert(pending_edges.size(), e);
    endtask

    function automatic longint near(longint c, longint span);
        longint unsigned u;
        u = {$urandom, $urandom};
        return c + longint'(u % longint'(2 * span + 1)) - span;
    endfunction

    // Random edges: mostly around the sphere, the rest anywhere
    task automatic add_random(int n);
        longint span;
        for (int k = 0; k < n; k++) begin
            span = 2 * longint'(radius) + 64;
            if ($urandom_range(0, 3) == 0) begin
                add_edge(longint'(signed'($urandom)), longint'(signed'($urandom)),
                         longint'(signed'($urandom)), longint'(signed'($urandom)),
                         longint'(signed'($urandom)), longint'(signed'($urandom)),
                         $urandom_range(0, 19) == 0);
            end else begin
                add_edge(near(ctr[0], span), near(ctr[1], span), near(ctr[2], span),
                         near(ctr[0], span), near(ctr[1], span), near(ctr[2], span),
                         $urandom_range(0, 19) == 0);
            end
        end
    endtask

    initial begin
        ctr = '{0, 0, 0};
        radius = '0;
        hit_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: centered sphere of radius 100 in Q.12 steps
        calm = 1'b1;
        set_sphere(32'd0, 32'd0, 32'd0, 32'd1600);
        add_edge(-3200, 0, 0, 3200, 0, 0, 1);       // straight through, two hits
        add_edge(-3200, 1600, 0, 3200, 1600, 0, 0); // tangent
        add_edge(-3200, 3200, 0, 3200, 3200, 0, 0); // misses: negative discriminant
        add_edge(500, 500, 500, 500, 500, 500, 0);  // zero length
        add_edge(5, 5, 5, 12, 3, 9, 0);             // short; flooring leaves a nonzero length
        add_edge(0, 0, 0, 3200, 0, 0, 0);           // starts inside, one hit
        add_edge(3200, 0, 0, 0, 0, 0, 0);           // ends inside, reversed
        add_edge(0, 0, 0, 160, 0, 0, 0);            // fully inside, no hit
        add_edge(-3200, -3200, -3200, 3200, 3200, 3200, 0);
        add_edge(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 -32'sh80000000, -32'sh80000000, -32'sh80000000, 0);
        add_edge(-32'sh80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, -32'sh80000000, 1);
        add_edge(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                 -32'sh80000000, -32'sh80000000, -32'sh80000000, 0);
        add_edge(0, -1600, -3200, 0, -1600, 3200, 0);
        drain();

        // Extreme centers and the largest radius
        set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        add_edge(-32'sh80000000, 0, 0, 32'h7fffffff, 0, 0, 1);
        add_edge(32'h7fffffff, -32'sh80000000, 32'h7fffffff,
                 -32'sh80000000, 32'h7fffffff, -32'sh80000000, 0);
        add_random(4);
        drain();

        // Random phases over several spheres
        calm = 1'b0;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_sphere(32'd0, 32'd0, 32'd0, 32'd0);
                1: set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
                2: set_sphere($urandom, $urandom, $urandom, 32'h80000000 | 32'd65536);
                default: set_sphere($urandom, $urandom, $urandom,
                                    $urandom_range(0, 3) == 0 ? $urandom
                                                              : $urandom_range(0, 1 << 24));
            endcase
            if (ph == 5) calm = 1'b1;
            if (ph == 6) calm = 1'b0;
            add_random(210);
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d edges, %0d results checked, %0d with two hits, %0d tangent",
                 edges_sent, results_checked, two_hit_edges, tangent_like);
        $display("sphere settings included extreme centers and radius 0 and maximum");
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_hits.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ssi_pkg.sv
src/ssi_front.sv
src/ssi_queue.sv
src/ssi_smul.sv
src/ssi_lane.sv
src/ssi_back.sv
src/segment_sphere_intersection_top.sv
bench/tb_segment_sphere_intersection_top.sv
